FILE: rtl/core/projectile_intercept_solver_core_macros.svh
// Assertion macros shared by the intercept solver RTL.
// Depends on nothing; included by the top level.
`ifndef PROJECTILE_INTERCEPT_SOLVER_CORE_MACROS_SVH
`define PROJECTILE_INTERCEPT_SOLVER_CORE_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define PIS_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Implication with a fixed delay in cycles between cause and effect.
`define PIS_ASSERT_DELAY(label, clk_s, rst_s, ante, dly, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/pis_pkg.sv
// Package for the intercept solver: widths, status codes and beat types.
// Depends on nothing; imported by every module of the solver.
package pis_pkg;

    // Field widths and fixed-point formats.
    localparam int COORD_W   = 24;
    localparam int TIME_FRAC = 16;
    localparam int TIME_W    = 32;
    localparam int SPEED_W   = 23;

    localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(256000);

    // Derived widths of the quadratic and of the solver datapath.
    localparam int D_W    = COORD_W + 1;
    localparam int COEF_W = 2 * COORD_W + 3;
    localparam int MAG_W  = COEF_W - 1;
    localparam int HALF_W = (MAG_W + 1) / 2;
    localparam int PROD_W = 2 * MAG_W;
    localparam int DISC_W = PROD_W + 1;
    localparam int ROOT_W = PROD_W / 2;
    localparam int NUM_W  = COEF_W + TIME_FRAC;
    localparam int QB     = TIME_W + 1;
    localparam int DR_W   = MAG_W + QB;

    // Pipeline depth, input beat to result strobe.
    localparam int FRONT_STAGES = 6;
    localparam int DIV_STAGES   = QB + 2;
    localparam int BACK_STAGES  = 3;
    localparam int LATENCY      = FRONT_STAGES + ROOT_W + DIV_STAGES + BACK_STAGES;

    // Root status codes.
    localparam logic [1:0] ST_TWO    = 2'd0;
    localparam logic [1:0] ST_DOUBLE = 2'd1;
    localparam logic [1:0] ST_NONE   = 2'd2;
    localparam logic [1:0] ST_AZERO  = 2'd3;

    // Time constants.
    localparam logic [TIME_W-1:0] T_NEG_ONE = TIME_W'(-(longint'(1) << TIME_FRAC));
    localparam logic [TIME_W-1:0] T_MAX     = {1'b0, {(TIME_W-1){1'b1}}};
    localparam logic [TIME_W-1:0] T_MIN     = {1'b1, {(TIME_W-1){1'b0}}};

    typedef logic [2:0][COORD_W-1:0] coord3_t;

    // Payload that travels beside the root and divide pipelines.
    typedef struct packed {
        coord3_t          pos;
        coord3_t          vel;
        logic [COEF_W-1:0] h;
        logic [COEF_W-1:0] a;
        logic [1:0]       status;
    } side_t;

    // Divider results for both roots.
    typedef struct packed {
        logic [QB-1:0] q1;
        logic [QB-1:0] q2;
        logic          neg1;
        logic          neg2;
        logic          ovf1;
        logic          ovf2;
    } div_res_t;

endpackage

FILE: rtl/core/pis_front.sv
// Front end of the intercept solver: offset, dot products, coefficients
// and discriminant over six register stages. Depends on pis_pkg.
module pis_front
    import pis_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               vld_in,
    input  coord3_t            pos,
    input  coord3_t            vel,
    input  coord3_t            muz,
    input  logic [SPEED_W-1:0] speed,
    output logic               vld_out,
    output side_t              side_out,
    output logic [PROD_W-1:0]  rad_out
);

    localparam int EW = 2 * HALF_W;
    localparam int SW = 2 * EW;

    logic [5:0] vld_reg;

    // Stage A: offset between target and muzzle.
    logic signed [COORD_W-1:0] pa_reg [3];
    logic signed [COORD_W-1:0] va_reg [3];
    logic signed [D_W-1:0]     da_reg [3];

    // Stage B: component products.
    logic signed [COORD_W-1:0]         pb_reg [3];
    logic signed [COORD_W-1:0]         vb_reg [3];
    logic signed [2*COORD_W-1:0]       vv_reg [3];
    logic signed [COORD_W+D_W-1:0]     vd_reg [3];
    logic signed [2*D_W-1:0]           dd_reg [3];
    logic [2*SPEED_W-1:0]              ss_reg;

    // Stage C: coefficients.
    coord3_t                  pc_reg;
    coord3_t                  vc_reg;
    logic signed [COEF_W-1:0] a_reg;
    logic signed [COEF_W-1:0] h_reg;
    logic signed [COEF_W-1:0] c_reg;

    // Stage D: partial products of h*h and a*c.
    coord3_t           pd_reg;
    coord3_t           vd2_reg;
    logic [COEF_W-1:0] hd_reg;
    logic [COEF_W-1:0] ad_reg;
    logic              az_d_reg;
    logic [EW-1:0]     h_ll_reg;
    logic [EW-1:0]     h_hl_reg;
    logic [EW-1:0]     h_hh_reg;
    logic [EW-1:0]     ac_ll_reg;
    logic [EW-1:0]     ac_lh_reg;
    logic [EW-1:0]     ac_hl_reg;
    logic [EW-1:0]     ac_hh_reg;

    // Stage E: full products h*h and a*c.
    coord3_t           pe_reg;
    coord3_t           ve_reg;
    logic [COEF_W-1:0] he_reg;
    logic [COEF_W-1:0] ae_reg;
    logic              az_e_reg;
    logic [PROD_W-1:0] h2_reg;
    logic [PROD_W-1:0] ac_reg;

    // Stage F: discriminant and status.
    side_t             side_f_reg;
    logic [PROD_W-1:0] rad_reg;

    logic signed [COEF_W-1:0] a_next;
    logic signed [COEF_W-1:0] h_next;
    logic signed [COEF_W-1:0] c_next;
    logic [MAG_W-1:0]         h_mag;
    logic [MAG_W-1:0]         a_mag;
    logic [EW-1:0]            hx;
    logic [EW-1:0]            ax;
    logic [EW-1:0]            cx;
    logic [PROD_W-1:0]        h2_next;
    logic [PROD_W-1:0]        ac_next;
    logic signed [DISC_W-1:0] disc_next;
    logic [1:0]               status_next;

    // Valid bits march with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[4:0], vld_in};
        end
    end

    // Coefficient sums.
    always_comb
    begin
        a_next = COEF_W'(vv_reg[0]) + COEF_W'(vv_reg[1]) + COEF_W'(vv_reg[2])
               - COEF_W'($signed({1'b0, ss_reg}));
        h_next = COEF_W'(vd_reg[0]) + COEF_W'(vd_reg[1]) + COEF_W'(vd_reg[2]);
        c_next = COEF_W'(dd_reg[0]) + COEF_W'(dd_reg[1]) + COEF_W'(dd_reg[2]);
    end

    // Magnitudes split into halves for the wide products.
    always_comb
    begin
        h_mag = h_reg[COEF_W-1] ? MAG_W'(-h_reg) : MAG_W'(h_reg);
        a_mag = a_reg[COEF_W-1] ? MAG_W'(-a_reg) : MAG_W'(a_reg);
        hx    = EW'(h_mag);
        ax    = EW'(a_mag);
        cx    = EW'(c_reg[MAG_W-1:0]);
    end

    // Recombine partial products.
    always_comb
    begin
        h2_next = PROD_W'((SW'(h_hh_reg) << EW) + (SW'(h_hl_reg) << (HALF_W + 1))
                          + SW'(h_ll_reg));
        ac_next = PROD_W'((SW'(ac_hh_reg) << EW)
                          + ((SW'(ac_lh_reg) + SW'(ac_hl_reg)) << HALF_W)
                          + SW'(ac_ll_reg));
    end

    // Discriminant h*h - a*c and the root class.
    always_comb
    begin
        if (ae_reg[COEF_W-1])
        begin
            disc_next = $signed({1'b0, h2_reg}) + $signed({1'b0, ac_reg});
        end
        else
        begin
            disc_next = $signed({1'b0, h2_reg}) - $signed({1'b0, ac_reg});
        end
        priority if (az_e_reg)
        begin
            status_next = ST_AZERO;
        end
        else if (disc_next[DISC_W-1])
        begin
            status_next = ST_NONE;
        end
        else if (disc_next == '0)
        begin
            status_next = ST_DOUBLE;
        end
        else
        begin
            status_next = ST_TWO;
        end
    end

    // Datapath registers of all six stages.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            pa_reg[k] <= $signed(pos[k]);
            va_reg[k] <= $signed(vel[k]);
            da_reg[k] <= D_W'($signed(pos[k])) - D_W'($signed(muz[k]));

            pb_reg[k] <= pa_reg[k];
            vb_reg[k] <= va_reg[k];
            vv_reg[k] <= va_reg[k] * va_reg[k];
            vd_reg[k] <= va_reg[k] * da_reg[k];
            dd_reg[k] <= da_reg[k] * da_reg[k];

            pc_reg[k] <= pb_reg[k];
            vc_reg[k] <= vb_reg[k];
        end
        ss_reg <= speed * speed;

        a_reg <= a_next;
        h_reg <= h_next;
        c_reg <= c_next;

        pd_reg    <= pc_reg;
        vd2_reg   <= vc_reg;
        hd_reg    <= h_reg;
        ad_reg    <= a_reg;
        az_d_reg  <= (a_reg == '0);
        h_ll_reg  <= hx[HALF_W-1:0] * hx[HALF_W-1:0];
        h_hl_reg  <= hx[EW-1:HALF_W] * hx[HALF_W-1:0];
        h_hh_reg  <= hx[EW-1:HALF_W] * hx[EW-1:HALF_W];
        ac_ll_reg <= ax[HALF_W-1:0] * cx[HALF_W-1:0];
        ac_lh_reg <= ax[HALF_W-1:0] * cx[EW-1:HALF_W];
        ac_hl_reg <= ax[EW-1:HALF_W] * cx[HALF_W-1:0];
        ac_hh_reg <= ax[EW-1:HALF_W] * cx[EW-1:HALF_W];

        pe_reg   <= pd_reg;
        ve_reg   <= vd2_reg;
        he_reg   <= hd_reg;
        ae_reg   <= ad_reg;
        az_e_reg <= az_d_reg;
        h2_reg   <= h2_next;
        ac_reg   <= ac_next;

        side_f_reg.pos    <= pe_reg;
        side_f_reg.vel    <= ve_reg;
        side_f_reg.h      <= he_reg;
        side_f_reg.a      <= ae_reg;
        side_f_reg.status <= status_next;
        rad_reg <= (status_next == ST_TWO) ? disc_next[PROD_W-1:0] : '0;
    end

    assign vld_out  = vld_reg[5];
    assign side_out = side_f_reg;
    assign rad_out  = rad_reg;

endmodule

FILE: rtl/core/pis_sqrt.sv
// Pipelined digit-by-digit square root, one root bit per stage.
// Depends on pis_pkg; carries the solver payload alongside.
module pis_sqrt
    import pis_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vld_in,
    input  side_t             side_in,
    input  logic [PROD_W-1:0] rad_in,
    output logic              vld_out,
    output side_t             side_out,
    output logic [ROOT_W-1:0] root_out
);

    localparam int RW = ROOT_W + 3;

    logic [ROOT_W-1:0] vld_reg;
    side_t             sd_reg   [ROOT_W];
    logic [PROD_W-1:0] x_reg    [ROOT_W];
    logic [RW-1:0]     rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    logic [PROD_W-1:0] x_next    [ROOT_W];
    logic [RW-1:0]     rem_next  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];

    // One trial subtraction per stage on the next two radicand bits.
    always_comb
    begin
        logic [PROD_W-1:0] sx;
        logic [RW-1:0]     srem;
        logic [ROOT_W-1:0] sroot;
        logic [RW-1:0]     rem2;
        logic [RW-1:0]     trial;
        logic              ge;
        for (int k = 0; k < ROOT_W; k++)
        begin
            if (k == 0)
            begin
                sx    = rad_in;
                srem  = '0;
                sroot = '0;
            end
            else
            begin
                sx    = x_reg[k-1];
                srem  = rem_reg[k-1];
                sroot = root_reg[k-1];
            end
            rem2  = {srem[RW-3:0], sx[PROD_W-1 -: 2]};
            trial = RW'({sroot, 2'b01});
            ge    = (rem2 >= trial);
            rem_next[k]  = ge ? (rem2 - trial) : rem2;
            root_next[k] = {sroot[ROOT_W-2:0], ge};
            x_next[k]    = sx << 2;
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[ROOT_W-2:0], vld_in};
        end
    end

    // Stage registers.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < ROOT_W; k++)
        begin
            x_reg[k]    <= x_next[k];
            rem_reg[k]  <= rem_next[k];
            root_reg[k] <= root_next[k];
            if (k == 0)
            begin
                sd_reg[k] <= side_in;
            end
            else
            begin
                sd_reg[k] <= sd_reg[k-1];
            end
        end
    end

    assign vld_out  = vld_reg[ROOT_W-1];
    assign side_out = sd_reg[ROOT_W-1];
    assign root_out = root_reg[ROOT_W-1];

endmodule

FILE: rtl/core/pis_div.sv
// Pipelined restoring divider for both roots over a shared divisor |a|.
// Depends on pis_pkg; one quotient bit per stage after two setup stages.
module pis_div
    import pis_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vld_in,
    input  side_t             side_in,
    input  logic [ROOT_W-1:0] root_in,
    output logic              vld_out,
    output side_t             side_out,
    output div_res_t          res_out
);

    localparam int NS_W = COEF_W + 1;

    // Stage G: numerator magnitudes, quotient signs and divisor magnitude.
    logic              g_vld_reg;
    side_t             g_side_reg;
    logic [NUM_W-1:0]  g_n1_reg;
    logic [NUM_W-1:0]  g_n2_reg;
    logic [MAG_W-1:0]  g_dm_reg;
    logic              g_neg1_reg;
    logic              g_neg2_reg;

    // Stage O: overflow check.
    logic              o_vld_reg;
    side_t             o_side_reg;
    logic [DR_W-1:0]   o_rem1_reg;
    logic [DR_W-1:0]   o_rem2_reg;
    logic [MAG_W-1:0]  o_dm_reg;
    logic [3:0]        o_flg_reg;

    // Quotient chain.
    logic [QB-1:0]     c_vld_reg;
    side_t             c_side_reg [QB];
    logic [DR_W-1:0]   c_rem1_reg [QB];
    logic [DR_W-1:0]   c_rem2_reg [QB];
    logic [QB-1:0]     c_q1_reg   [QB];
    logic [QB-1:0]     c_q2_reg   [QB];
    logic [MAG_W-1:0]  c_dm_reg   [QB];
    logic [3:0]        c_flg_reg  [QB];

    logic signed [NS_W-1:0] n1;
    logic signed [NS_W-1:0] n2;
    logic [COEF_W-1:0]      nm1;
    logic [COEF_W-1:0]      nm2;
    logic                   aneg;
    logic [MAG_W-1:0]       dm;

    logic [DR_W-1:0] rem1_next [QB];
    logic [DR_W-1:0] rem2_next [QB];
    logic [QB-1:0]   q1_next   [QB];
    logic [QB-1:0]   q2_next   [QB];

    // Numerators sqrt - h and -h - sqrt, as sign and magnitude.
    always_comb
    begin
        n1   = NS_W'($signed({1'b0, root_in})) - NS_W'($signed(side_in.h));
        n2   = -NS_W'($signed(side_in.h)) - NS_W'($signed({1'b0, root_in}));
        nm1  = n1[NS_W-1] ? COEF_W'(-n1) : COEF_W'(n1);
        nm2  = n2[NS_W-1] ? COEF_W'(-n2) : COEF_W'(n2);
        aneg = side_in.a[COEF_W-1];
        dm   = aneg ? MAG_W'(-$signed(side_in.a)) : MAG_W'(side_in.a);
    end

    // One quotient bit per stage, most significant first.
    always_comb
    begin
        logic [DR_W-1:0] r1;
        logic [DR_W-1:0] r2;
        logic [QB-1:0]   sq1;
        logic [QB-1:0]   sq2;
        logic [DR_W-1:0] trial;
        logic            ge1;
        logic            ge2;
        for (int k = 0; k < QB; k++)
        begin
            if (k == 0)
            begin
                r1    = o_rem1_reg;
                r2    = o_rem2_reg;
                sq1   = '0;
                sq2   = '0;
                trial = DR_W'(o_dm_reg) << (QB - 1 - k);
            end
            else
            begin
                r1    = c_rem1_reg[k-1];
                r2    = c_rem2_reg[k-1];
                sq1   = c_q1_reg[k-1];
                sq2   = c_q2_reg[k-1];
                trial = DR_W'(c_dm_reg[k-1]) << (QB - 1 - k);
            end
            ge1 = (r1 >= trial);
            ge2 = (r2 >= trial);
            rem1_next[k] = ge1 ? (r1 - trial) : r1;
            rem2_next[k] = ge2 ? (r2 - trial) : r2;
            q1_next[k]   = {sq1[QB-2:0], ge1};
            q2_next[k]   = {sq2[QB-2:0], ge2};
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
            c_vld_reg <= '0;
        end
        else
        begin
            g_vld_reg <= vld_in;
            o_vld_reg <= g_vld_reg;
            c_vld_reg <= {c_vld_reg[QB-2:0], o_vld_reg};
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        g_side_reg <= side_in;
        g_n1_reg   <= {nm1, {TIME_FRAC{1'b0}}};
        g_n2_reg   <= {nm2, {TIME_FRAC{1'b0}}};
        g_dm_reg   <= dm;
        g_neg1_reg <= n1[NS_W-1] ^ aneg;
        g_neg2_reg <= n2[NS_W-1] ^ aneg;

        o_side_reg <= g_side_reg;
        o_rem1_reg <= DR_W'(g_n1_reg);
        o_rem2_reg <= DR_W'(g_n2_reg);
        o_dm_reg   <= g_dm_reg;
        o_flg_reg  <= {g_neg1_reg, g_neg2_reg,
                       DR_W'(g_n1_reg) >= (DR_W'(g_dm_reg) << QB),
                       DR_W'(g_n2_reg) >= (DR_W'(g_dm_reg) << QB)};

        for (int k = 0; k < QB; k++)
        begin
            c_rem1_reg[k] <= rem1_next[k];
            c_rem2_reg[k] <= rem2_next[k];
            c_q1_reg[k]   <= q1_next[k];
            c_q2_reg[k]   <= q2_next[k];
            if (k == 0)
            begin
                c_side_reg[k] <= o_side_reg;
                c_dm_reg[k]   <= o_dm_reg;
                c_flg_reg[k]  <= o_flg_reg;
            end
            else
            begin
                c_side_reg[k] <= c_side_reg[k-1];
                c_dm_reg[k]   <= c_dm_reg[k-1];
                c_flg_reg[k]  <= c_flg_reg[k-1];
            end
        end
    end

    assign vld_out       = c_vld_reg[QB-1];
    assign side_out      = c_side_reg[QB-1];
    assign res_out.q1    = c_q1_reg[QB-1];
    assign res_out.q2    = c_q2_reg[QB-1];
    assign res_out.neg1  = c_flg_reg[QB-1][3];
    assign res_out.neg2  = c_flg_reg[QB-1][2];
    assign res_out.ovf1  = c_flg_reg[QB-1][1];
    assign res_out.ovf2  = c_flg_reg[QB-1][0];

endmodule

FILE: rtl/core/pis_back.sv
// Back end of the intercept solver: root choice, time saturation,
// predicted position and output registers. Depends on pis_pkg.
module pis_back
    import pis_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vld_in,
    input  side_t             side_in,
    input  div_res_t          res_in,
    output logic              done,
    output logic [TIME_W-1:0] time_out,
    output coord3_t           pred_out,
    output logic [1:0]        status_out,
    output logic              sat_out
);

    localparam int MV_W  = COORD_W + TIME_W;
    localparam int SUM_W = MV_W - TIME_FRAC + 1;
    localparam logic signed [SUM_W-1:0] CMAX_S = SUM_W'((longint'(1) << (COORD_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] CMIN_S = -CMAX_S - SUM_W'(1);

    // Stage H.
    logic                     h_vld_reg;
    logic signed [TIME_W-1:0] h_t_reg;
    logic                     h_sat_reg;
    logic [1:0]               h_status_reg;
    coord3_t                  h_pos_reg;
    coord3_t                  h_vel_reg;

    // Stage I.
    logic                     i_vld_reg;
    logic signed [MV_W-1:0]   i_mv_reg [3];
    coord3_t                  i_pos_reg;
    logic [TIME_W-1:0]        i_t_reg;
    logic                     i_sat_reg;
    logic [1:0]               i_status_reg;

    // Output stage.
    logic                     done_reg;
    logic [TIME_W-1:0]        time_reg;
    coord3_t                  pred_reg;
    logic [1:0]               status_reg;
    logic                     sat_reg;

    logic [TIME_W:0]          c1;
    logic [TIME_W:0]          c2;
    logic signed [TIME_W-1:0] x1;
    logic signed [TIME_W-1:0] x2;
    logic signed [TIME_W-1:0] t_next;
    logic                     sat_next;
    coord3_t                  pred_next;
    logic                     csat_next;

    // Truncated quotient to saturated time, with the clamp flag on top.
    function automatic logic [TIME_W:0] clamp_q(input logic [QB-1:0] q,
                                                input logic neg, input logic ovf);
        logic [TIME_W:0] r;
        if (ovf)
        begin
            r = {1'b1, neg ? T_MIN : T_MAX};
        end
        else if (!neg)
        begin
            if (q > QB'(T_MAX))
            begin
                r = {1'b1, T_MAX};
            end
            else
            begin
                r = {1'b0, q[TIME_W-1:0]};
            end
        end
        else
        begin
            if (q > QB'(T_MIN))
            begin
                r = {1'b1, T_MIN};
            end
            else
            begin
                r = {1'b0, -q[TIME_W-1:0]};
            end
        end
        return r;
    endfunction

    // Root choice: the smallest positive root, else the plus-sign root.
    always_comb
    begin
        c1 = clamp_q(res_in.q1, res_in.neg1, res_in.ovf1);
        c2 = clamp_q(res_in.q2, res_in.neg2, res_in.ovf2);
        x1 = $signed(c1[TIME_W-1:0]);
        x2 = $signed(c2[TIME_W-1:0]);
        unique case (side_in.status)
            ST_TWO:
            begin
                if (((x1 < 0) && (x2 > 0)) || ((x1 > 0) && (x2 > 0) && (x2 < x1)))
                begin
                    t_next   = x2;
                    sat_next = c2[TIME_W];
                end
                else
                begin
                    t_next   = x1;
                    sat_next = c1[TIME_W];
                end
            end
            ST_DOUBLE:
            begin
                t_next   = x1;
                sat_next = c1[TIME_W];
            end
            ST_NONE, ST_AZERO:
            begin
                t_next   = $signed(T_NEG_ONE);
                sat_next = 1'b0;
            end
        endcase
    end

    // Position at the chosen time: floor shift, add, clamp per axis.
    always_comb
    begin
        logic signed [SUM_W-2:0] moved;
        logic signed [SUM_W-1:0] sum;
        csat_next = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            moved = (SUM_W-1)'(i_mv_reg[k] >>> TIME_FRAC);
            sum   = SUM_W'($signed(i_pos_reg[k])) + SUM_W'(moved);
            if (sum > CMAX_S)
            begin
                pred_next[k] = COORD_W'(CMAX_S);
                csat_next    = 1'b1;
            end
            else if (sum < CMIN_S)
            begin
                pred_next[k] = COORD_W'(CMIN_S);
                csat_next    = 1'b1;
            end
            else
            begin
                pred_next[k] = COORD_W'(sum);
            end
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_vld_reg <= 1'b0;
            i_vld_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            h_vld_reg <= vld_in;
            i_vld_reg <= h_vld_reg;
            done_reg  <= i_vld_reg;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        h_t_reg      <= t_next;
        h_sat_reg    <= sat_next;
        h_status_reg <= side_in.status;
        h_pos_reg    <= side_in.pos;
        h_vel_reg    <= side_in.vel;

        for (int k = 0; k < 3; k++)
        begin
            i_mv_reg[k] <= $signed(h_vel_reg[k]) * h_t_reg;
        end
        i_pos_reg    <= h_pos_reg;
        i_t_reg      <= h_t_reg;
        i_sat_reg    <= h_sat_reg;
        i_status_reg <= h_status_reg;

        time_reg   <= i_t_reg;
        pred_reg   <= pred_next;
        status_reg <= i_status_reg;
        sat_reg    <= i_sat_reg | csat_next;
    end

    assign done       = done_reg;
    assign time_out   = time_reg;
    assign pred_out   = pred_reg;
    assign status_out = status_reg;
    assign sat_out    = sat_reg;

endmodule

FILE: rtl/core/projectile_intercept_solver_core.sv
// Projectile intercept solver: top level with the speed register.
// Depends on pis_pkg, pis_front, pis_sqrt, pis_div, pis_back and the macro header.
//
// Usage:
//   Drive the nine coordinate inputs and raise start for one cycle per
//   target-muzzle pair; a beat is taken at every rising edge with start high
//   and busy low. busy is always low, so a new beat may enter every cycle.
//   Each beat yields one result beat: done is high for exactly one cycle with
//   intercept_time, predicted_x/y/z, root_status and saturated valid in that
//   cycle. The receiver cannot stall; results must be taken as they appear.
//   Each beat passes six coefficient stages, one square-root bit per stage
//   (50), two divider setup stages plus one quotient bit per stage (33), and
//   three stages for root choice, motion product and clamping.
//   Throughput is one beat per cycle.
//   projectile_speed is written with cfg_wr_en / cfg_wr_data and should
//   change only while no beat is in flight. Reset clears all valid bits at
//   once and loads the speed register with 1000.0 units per second.
`include "projectile_intercept_solver_core_macros.svh"

module projectile_intercept_solver_core
    import pis_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      cfg_wr_en,
    input  logic [SPEED_W-1:0]        cfg_wr_data,
    input  logic signed [COORD_W-1:0] target_pos_x,
    input  logic signed [COORD_W-1:0] target_pos_y,
    input  logic signed [COORD_W-1:0] target_pos_z,
    input  logic signed [COORD_W-1:0] target_vel_x,
    input  logic signed [COORD_W-1:0] target_vel_y,
    input  logic signed [COORD_W-1:0] target_vel_z,
    input  logic signed [COORD_W-1:0] muzzle_x,
    input  logic signed [COORD_W-1:0] muzzle_y,
    input  logic signed [COORD_W-1:0] muzzle_z,
    output logic                      done,
    output logic signed [TIME_W-1:0]  intercept_time,
    output logic signed [COORD_W-1:0] predicted_x,
    output logic signed [COORD_W-1:0] predicted_y,
    output logic signed [COORD_W-1:0] predicted_z,
    output logic [1:0]                root_status,
    output logic                      saturated
);

    logic [SPEED_W-1:0] speed_reg;

    coord3_t           pos_in;
    coord3_t           vel_in;
    coord3_t           muz_in;
    logic              accept;

    logic              f_vld;
    side_t             f_side;
    logic [PROD_W-1:0] f_rad;
    logic              s_vld;
    side_t             s_side;
    logic [ROOT_W-1:0] s_root;
    logic              d_vld;
    side_t             d_side;
    div_res_t          d_res;
    logic [TIME_W-1:0] t_out;
    coord3_t           pred;

    // The pipeline never stalls.
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Projectile speed register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= SPEED_RESET;
        end
        else if (cfg_wr_en)
        begin
            speed_reg <= cfg_wr_data;
        end
    end

    // Input vectors, index 0 is x.
    assign pos_in = {target_pos_z, target_pos_y, target_pos_x};
    assign vel_in = {target_vel_z, target_vel_y, target_vel_x};
    assign muz_in = {muzzle_z, muzzle_y, muzzle_x};

    pis_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld_in   (accept),
        .pos      (pos_in),
        .vel      (vel_in),
        .muz      (muz_in),
        .speed    (speed_reg),
        .vld_out  (f_vld),
        .side_out (f_side),
        .rad_out  (f_rad)
    );

    pis_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld_in   (f_vld),
        .side_in  (f_side),
        .rad_in   (f_rad),
        .vld_out  (s_vld),
        .side_out (s_side),
        .root_out (s_root)
    );

    pis_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld_in   (s_vld),
        .side_in  (s_side),
        .root_in  (s_root),
        .vld_out  (d_vld),
        .side_out (d_side),
        .res_out  (d_res)
    );

    pis_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .vld_in     (d_vld),
        .side_in    (d_side),
        .res_in     (d_res),
        .done       (done),
        .time_out   (t_out),
        .pred_out   (pred),
        .status_out (root_status),
        .sat_out    (saturated)
    );

    assign intercept_time = $signed(t_out);
    assign predicted_x    = $signed(pred[0]);
    assign predicted_y    = $signed(pred[1]);
    assign predicted_z    = $signed(pred[2]);

    // Every accepted beat comes out after the fixed pipeline depth.
    `PIS_ASSERT_DELAY(a_latency, clk, rst_n, accept, LATENCY, done, "result beat missing")
    // Without a usable root the time is minus one second.
    `PIS_ASSERT_IMPLY(a_noroot_time, clk, rst_n, done && (root_status == ST_NONE || root_status == ST_AZERO), intercept_time == $signed(T_NEG_ONE), "no-root time wrong")
    // A result strobe never appears without an accepted beat that has passed the whole pipeline.
    `PIS_ASSERT_IMPLY(a_no_spurious, clk, rst_n, done, $past(accept, LATENCY), "spurious result beat")

endmodule

FILE: bench/tb_projectile_intercept_solver_core.sv
// Self-checking testbench for projectile_intercept_solver_core.
// Depends on pis_pkg and the solver RTL; each beat is checked against a literal
// expectation or an exact wide-integer predictor of the intercept solution.
`timescale 1ns / 1ps

module tb_projectile_intercept_solver_core
    import pis_pkg::*;
();

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic signed [COORD_W-1:0] px, py, pz, vx, vy, vz, mx, my, mz;
    } pair_t;

    typedef struct {
        logic signed [TIME_W-1:0]  t;
        logic signed [COORD_W-1:0] x, y, z;
        logic [1:0]                status;
        logic                      sat;
    } solution_t;

    typedef struct {
        pair_t     q;
        bit        lit;
        solution_t e;
    } row_t;

    localparam int IDLE_LIMIT = 5000;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      cfg_wr_en = 1'b0;
    logic [SPEED_W-1:0]        cfg_wr_data = '0;
    logic signed [COORD_W-1:0] target_pos_x = '0, target_pos_y = '0, target_pos_z = '0;
    logic signed [COORD_W-1:0] target_vel_x = '0, target_vel_y = '0, target_vel_z = '0;
    logic signed [COORD_W-1:0] muzzle_x = '0, muzzle_y = '0, muzzle_z = '0;
    logic                      done;
    logic signed [TIME_W-1:0]  intercept_time;
    logic signed [COORD_W-1:0] predicted_x, predicted_y, predicted_z;
    logic [1:0]                root_status;
    logic                      saturated;

    // Expectation attached to the beat currently on the inputs.
    bit        lit_on = 1'b0;
    solution_t lit_sol;

    logic [SPEED_W-1:0] speed_model = SPEED_RESET;
    solution_t          pending_solutions[$];
    int                 fails = 0;
    int                 idle_cycles = 0;
    int                 burst_left = 0;

    projectile_intercept_solver_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .target_pos_x(target_pos_x), .target_pos_y(target_pos_y),
        .target_pos_z(target_pos_z), .target_vel_x(target_vel_x),
        .target_vel_y(target_vel_y), .target_vel_z(target_vel_z),
        .muzzle_x(muzzle_x), .muzzle_y(muzzle_y), .muzzle_z(muzzle_z),
        .done(done), .intercept_time(intercept_time), .predicted_x(predicted_x),
        .predicted_y(predicted_y), .predicted_z(predicted_z),
        .root_status(root_status), .saturated(saturated)
    );

    always #1 clk = ~clk;

    // Clamp a wide value into [lo, hi] and note any clamping.
    function automatic wide_t clamp_wide(wide_t x, wide_t lo, wide_t hi, inout bit flag);
        if (x < lo)
        begin
            flag = 1'b1;
            return lo;
        end
        if (x > hi)
        begin
            flag = 1'b1;
            return hi;
        end
        return x;
    endfunction

    // Exact intercept solution for one target-muzzle pair at the given speed.
    function automatic solution_t solve_intercept(pair_t q, logic [SPEED_W-1:0] spd);
        wide_t     p[3], v[3], m[3];
        wide_t     d, vv, h, c, a, disc, sq, cand, x1, x2, t, mv, pr, spw;
        wide_t     tlo, thi, clo, chi, scl;
        bit        s1, s2, sat;
        solution_t r;
        p[0] = q.px; p[1] = q.py; p[2] = q.pz;
        v[0] = q.vx; v[1] = q.vy; v[2] = q.vz;
        m[0] = q.mx; m[1] = q.my; m[2] = q.mz;
        tlo = -(wide_t'(1) <<< 31);
        thi = (wide_t'(1) <<< 31) - 1;
        clo = -(wide_t'(1) <<< (COORD_W - 1));
        chi = (wide_t'(1) <<< (COORD_W - 1)) - 1;
        scl = wide_t'(1) <<< TIME_FRAC;
        vv = '0; h = '0; c = '0; sat = 1'b0; s1 = 1'b0; s2 = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            d = p[k] - m[k];
            vv = vv + v[k] * v[k];
            h = h + v[k] * d;
            c = c + d * d;
        end
        spw = {233'd0, spd};
        a = vv - spw * spw;
        if (a == 0)
        begin
            r.status = ST_AZERO;
            t = -scl;
        end
        else
        begin
            disc = h * h - a * c;
            if (disc < 0)
            begin
                r.status = ST_NONE;
                t = -scl;
            end
            else if (disc == 0)
            begin
                r.status = ST_DOUBLE;
                t = clamp_wide(((-h) * scl) / a, tlo, thi, sat);
            end
            else
            begin
                // Floor square root, one bit at a time.
                sq = '0;
                for (int i = 80; i >= 0; i--)
                begin
                    cand = sq | (wide_t'(1) <<< i);
                    if (cand * cand <= disc)
                        sq = cand;
                end
                x1 = clamp_wide(((sq - h) * scl) / a, tlo, thi, s1);
                x2 = clamp_wide(((-h - sq) * scl) / a, tlo, thi, s2);
                r.status = ST_TWO;
                if ((x1 < 0 && x2 > 0) || (x1 > 0 && x2 > 0 && x2 < x1))
                begin
                    t = x2;
                    sat = s2;
                end
                else
                begin
                    t = x1;
                    sat = s1;
                end
            end
        end
        r.t = t[TIME_W-1:0];
        for (int k = 0; k < 3; k++)
        begin
            mv = v[k] * t;
            mv = mv >>> TIME_FRAC;
            pr = clamp_wide(p[k] + mv, clo, chi, sat);
            if (k == 0) r.x = pr[COORD_W-1:0];
            else if (k == 1) r.y = pr[COORD_W-1:0];
            else r.z = pr[COORD_W-1:0];
        end
        r.sat = sat;
        return r;
    endfunction

    // Result checking, expectation capture and the speed register model.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_solutions.size() == 0)
                begin
                    $error("result beat with no expectation waiting");
                    fails++;
                end
                else
                begin
                    solution_t e;
                    e = pending_solutions.pop_front();
                    if (intercept_time !== e.t)
                    begin
                        $error("intercept_time expected %0d got %0d", e.t, intercept_time);
                        fails++;
                    end
                    if (predicted_x !== e.x)
                    begin
                        $error("predicted_x expected %0d got %0d", e.x, predicted_x);
                        fails++;
                    end
                    if (predicted_y !== e.y)
                    begin
                        $error("predicted_y expected %0d got %0d", e.y, predicted_y);
                        fails++;
                    end
                    if (predicted_z !== e.z)
                    begin
                        $error("predicted_z expected %0d got %0d", e.z, predicted_z);
                        fails++;
                    end
                    if (root_status !== e.status)
                    begin
                        $error("root_status expected %0d got %0d", e.status, root_status);
                        fails++;
                    end
                    if (saturated !== e.sat)
                    begin
                        $error("saturated expected %0d got %0d", e.sat, saturated);
                        fails++;
                    end
                end
            end
            if (start && !busy)
            begin
                pair_t q;
                q.px = target_pos_x; q.py = target_pos_y; q.pz = target_pos_z;
                q.vx = target_vel_x; q.vy = target_vel_y; q.vz = target_vel_z;
                q.mx = muzzle_x; q.my = muzzle_y; q.mz = muzzle_z;
                if (lit_on)
                    pending_solutions.push_back(lit_sol);
                else
                    pending_solutions.push_back(solve_intercept(q, speed_model));
            end
            if (cfg_wr_en)
                speed_model <= cfg_wr_data;
            // Watchdog on cycles in which no beat moves.
            if (done || (start && !busy))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("tb_projectile_intercept_solver_core failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic signed [COORD_W-1:0] rand_coord(int bound);
        return COORD_W'($signed($urandom_range(0, 2 * bound)) - bound);
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0: return {1'b0, {(COORD_W-1){1'b1}}};
            1: return {1'b1, {(COORD_W-1){1'b0}}};
            2: return '0;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    // Random pair: half solvable geometry, the rest noise, fast, a-zero or extremes.
    function automatic pair_t random_pair(logic [SPEED_W-1:0] spd);
        pair_t q;
        int    vb, sel;
        sel = $urandom_range(0, 9);
        vb = int'(spd >> 2) + 1;
        q.px = rand_coord(1 << 20); q.py = rand_coord(1 << 20); q.pz = rand_coord(1 << 20);
        q.mx = rand_coord(1 << 18); q.my = rand_coord(1 << 18); q.mz = rand_coord(1 << 18);
        q.vx = rand_coord(vb); q.vy = rand_coord(vb); q.vz = rand_coord(vb);
        if (sel < 2)
        begin
            q.px = COORD_W'($urandom); q.py = COORD_W'($urandom); q.pz = COORD_W'($urandom);
            q.vx = COORD_W'($urandom); q.vy = COORD_W'($urandom); q.vz = COORD_W'($urandom);
            q.mx = COORD_W'($urandom); q.my = COORD_W'($urandom); q.mz = COORD_W'($urandom);
        end
        else if (sel == 7)
        begin
            // Target speed equal to the projectile speed along one axis.
            q.vx = '0; q.vy = '0; q.vz = '0;
            case ($urandom_range(0, 2))
                0: q.vx = $urandom_range(0, 1) ? COORD_W'(spd) : -COORD_W'(spd);
                1: q.vy = $urandom_range(0, 1) ? COORD_W'(spd) : -COORD_W'(spd);
                default: q.vz = $urandom_range(0, 1) ? COORD_W'(spd) : -COORD_W'(spd);
            endcase
        end
        else if (sel == 8)
        begin
            q.vx = rand_coord(8388607); q.vy = rand_coord(8388607); q.vz = rand_coord(8388607);
        end
        else if (sel == 9)
        begin
            q.px = pick_extreme(); q.py = pick_extreme(); q.pz = pick_extreme();
            q.vx = pick_extreme(); q.vy = pick_extreme(); q.vz = pick_extreme();
            q.mx = pick_extreme(); q.my = pick_extreme(); q.mz = pick_extreme();
        end
        return q;
    endfunction

    // Drive one beat and hold it until taken; random bursts and gaps follow.
    task automatic send_pair(pair_t q, bit lit, solution_t e);
        @(negedge clk);
        target_pos_x <= q.px; target_pos_y <= q.py; target_pos_z <= q.pz;
        target_vel_x <= q.vx; target_vel_y <= q.vy; target_vel_z <= q.vz;
        muzzle_x <= q.mx; muzzle_y <= q.my; muzzle_z <= q.mz;
        lit_on <= lit;
        lit_sol <= e;
        start <= 1'b1;
        #0.1;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 40);
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 11)) @(negedge clk);
        end
    endtask

    task automatic drain_solutions();
        @(negedge clk);
        start <= 1'b0;
        while (pending_solutions.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_speed(logic [SPEED_W-1:0] spd);
        drain_solutions();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= spd;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Directed rows, literal expectations only for the obvious cases.
    function automatic row_t mk_row(int px, int py, int pz, int vx, int vy, int vz,
                                    int mx, int my, int mz, bit lit, int et,
                                    int ex, int ey, int ez, logic [1:0] es, bit esat);
        row_t r;
        r.q.px = COORD_W'(px); r.q.py = COORD_W'(py); r.q.pz = COORD_W'(pz);
        r.q.vx = COORD_W'(vx); r.q.vy = COORD_W'(vy); r.q.vz = COORD_W'(vz);
        r.q.mx = COORD_W'(mx); r.q.my = COORD_W'(my); r.q.mz = COORD_W'(mz);
        r.lit = lit;
        r.e.t = TIME_W'(et);
        r.e.x = COORD_W'(ex); r.e.y = COORD_W'(ey); r.e.z = COORD_W'(ez);
        r.e.status = es; r.e.sat = esat;
        return r;
    endfunction

    initial
    begin
        row_t              rows[$];
        solution_t         none;
        logic [SPEED_W-1:0] speeds[6];
        int                per_phase;
        int                hi, lo;
        hi = 8388607;
        lo = -8388608;
        none = '{default: '0};
        speeds[0] = SPEED_RESET;
        speeds[1] = '0;
        speeds[2] = {SPEED_W{1'b1}};
        speeds[3] = SPEED_W'(1);
        speeds[4] = SPEED_W'($urandom_range(1000, 4000000));
        speeds[5] = SPEED_RESET;

        // Target at the muzzle and at rest: double root at zero.
        rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0,
                              1, 0, 0, 0, 0, ST_DOUBLE, 0));
        // Target as fast as the projectile: a is zero.
        rows.push_back(mk_row(0, 0, 0, 256000, 0, 0, 0, 0, 0,
                              1, -65536, -256000, 0, 0, ST_AZERO, 0));
        // Fast target crossing sideways: no real root.
        rows.push_back(mk_row(25600, 0, 0, 0, hi, 0, 0, 0, 0,
                              1, -65536, 25600, -hi, 0, ST_NONE, 0));
        rows.push_back(mk_row(25600, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(25600, 2560, -2560, 2560, -2560, 256, 0, 0, 0,
                              0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(hi, hi, hi, hi, hi, hi, hi, hi, hi, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(lo, lo, lo, lo, lo, lo, lo, lo, lo, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(hi, lo, hi, lo, hi, lo, lo, hi, lo, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(hi, hi, hi, 0, 0, 0, lo, lo, lo, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(lo, 0, 0, 255999, 0, 0, hi, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(100000, 0, 0, -300000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(100000, 0, 0, 300000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(-1, -1, -1, -1, -1, -1, -1, -1, -1, 0, 0, 0, 0, 0, 0, 0));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
            send_pair(rows[i].q, rows[i].lit, rows[i].e);

        per_phase = 155;
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph > 0)
                write_speed(speeds[ph]);
            for (int n = 0; n < per_phase; n++)
            begin
                // Let the pipeline empty once mid-run.
                if (ph == 2 && n == per_phase / 2)
                    drain_solutions();
                send_pair(random_pair(speed_model), 1'b0, none);
            end
        end

        drain_solutions();
        repeat (10) @(posedge clk);
        if (fails == 0 && pending_solutions.size() == 0)
            $display("tb_projectile_intercept_solver_core passed");
        else
            $display("tb_projectile_intercept_solver_core failed");
        $finish;
    end

endmodule
